// ===== rtl/core/hbmt_pkg.sv =====
// Shared types and constants for the heartbeat membership table.
// Used by the table cell and the top level; no dependencies.
`timescale 1ns / 1ps
package hbmt_pkg;

    typedef enum logic [1:0] {
        KIND_MERGE = 2'd0,
        KIND_SWEEP = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_ADDED      = 4'd0,
        ST_UPDATED    = 4'd1,
        ST_STALE      = 4'd2,
        ST_FULL       = 4'd3,
        ST_REMOVED    = 4'd4,
        ST_SWEPT      = 4'd5,
        ST_READ_OK    = 4'd6,
        ST_READ_EMPTY = 4'd7,
        ST_CLEARED    = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        CFG_SELF_ID    = 2'd0,
        CFG_SELF_PORT  = 2'd1,
        CFG_FAIL_TO    = 2'd2,
        CFG_REMOVE_TO  = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_WALK,
        FSM_EMIT,
        FSM_DONE
    } fsm_t;

    // One member entry as it travels between cells.
    typedef struct packed {
        logic        valid;
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] heartbeat;
        logic [31:0] stamp;
        logic        failed;
        logic [31:0] since;
    } entry_t;

    localparam logic [31:0] FAIL_TO_RESET   = 32'd5;
    localparam logic [31:0] REMOVE_TO_RESET = 32'd20;

    // Most entries that one sweep may remove.
    localparam int MAX_REMOVALS = 32;

endpackage

// ===== rtl/core/hbmt_cell.sv =====
// One table cell: holds a member entry and passes it to its neighbor on a shift.
// Depends on hbmt_pkg.
`timescale 1ns / 1ps
module hbmt_cell
    import hbmt_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   shift,
    input  logic   clear,
    input  entry_t entry_in,
    output entry_t entry_out
);

    entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid  <= 1'b0;
            entry_reg.failed <= 1'b0;
        end else if (clear) begin
            entry_reg.valid  <= 1'b0;
            entry_reg.failed <= 1'b0;
        end else if (shift) begin
            entry_reg.valid  <= entry_in.valid;
            entry_reg.failed <= entry_in.failed;
        end
        if (shift) begin
            entry_reg.id        <= entry_in.id;
            entry_reg.port      <= entry_in.port;
            entry_reg.heartbeat <= entry_in.heartbeat;
            entry_reg.stamp     <= entry_in.stamp;
            entry_reg.since     <= entry_in.since;
        end
    end

    assign entry_out = entry_reg;

endmodule

// ===== rtl/core/heartbeat_membership_table_unit.sv =====
// Heartbeat membership table top level: cell ring, sequencer and stream ports.
// Depends on hbmt_pkg and hbmt_cell.
`timescale 1ns / 1ps
// The table is a ring of TABLE_DEPTH cells that rotates by one slot per cycle
// while a beat walks it and no sweep stalls it. A read or a sweep makes one
// full rotation and a merge two, so slot 0 sits at the head of the ring again
// when the beat finishes. A clear empties every cell without rotating; else the
// head cell is the only place an entry is inspected or modified. A merge first
// walks the ring once to find the first matching id and the lowest free slot,
// then walks it a second time to apply the update or the insertion. A sweep
// walks once, ages each entry as it passes the head and stalls the rotation
// while a removal beat waits on the result channel; at most 32 entries are
// removed in one sweep and any further due entries wait for a later sweep. A
// read rotates once and captures the requested slot. Results leave through a
// single output register, one beat at a time, with last high on the final beat
// of each input item. Config writes are accepted at any time and must only be
// issued while the block is idle.
module heartbeat_membership_table_unit
    import hbmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input beat. tdata: entry_id[31:0], entry_port[47:32],
    // entry_heartbeat[79:48], current_time[111:80], slot_index[116:112].
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic [1:0]   s_tuser,   // kind[1:0]
    // Result beat. tdata: out_id[31:0], out_port[47:32], out_heartbeat[79:48],
    // out_time[111:80], out_failed[112].
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,
    output logic [3:0]   m_tuser,   // status[3:0]
    output logic         m_tlast,
    // Configuration write channel.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    // Configuration registers.
    logic [31:0] self_id_reg, fail_to_reg, remove_to_reg;
    logic [15:0] self_port_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            self_id_reg   <= '0;
            self_port_reg <= '0;
            fail_to_reg   <= FAIL_TO_RESET;
            remove_to_reg <= REMOVE_TO_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SELF_ID:   self_id_reg   <= cfg_data;
                CFG_SELF_PORT: self_port_reg <= cfg_data[15:0];
                CFG_FAIL_TO:   fail_to_reg   <= cfg_data;
                CFG_REMOVE_TO: remove_to_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Cell ring. Cell 0 is the head; the head entry, possibly updated, feeds back at the tail.
    entry_t cell_q [TABLE_DEPTH];
    entry_t head_new;
    logic   shift, clear_all;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        entry_t din;
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign din = head_new;
        end else begin : g_mid
            assign din = cell_q[g + 1];
        end
        hbmt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift    (shift),
            .clear    (clear_all),
            .entry_in (din),
            .entry_out(cell_q[g])
        );
    end

    entry_t head;
    assign head = cell_q[0];

    // Captured input beat.
    kind_t       kind_reg;
    logic [31:0] id_reg, hb_reg, now_reg;
    logic [15:0] port_reg;
    logic [4:0]  slot_reg;

    fsm_t        state_reg, state_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic        pass_reg, pass_next;           // merge: 0 search, 1 apply
    logic        found_reg, found_next, free_ok_reg, free_ok_next;
    logic [IW-1:0] found_idx_reg, found_idx_next, free_idx_reg, free_idx_next;
    logic [5:0]  rem_cnt_reg, rem_cnt_next;     // removals in the current sweep
    logic        s_take;

    // Output register.
    logic         ovalid_reg, ovalid_next;
    logic [119:0] odata_reg, odata_next;
    logic [3:0]   ostat_reg, ostat_next;
    logic         olast_reg, olast_next;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;

    assign s_tready = (state_reg == FSM_IDLE) && !ovalid_reg;
    assign s_take   = s_tvalid && s_tready;

    function automatic logic [119:0] pack_entry(entry_t e);
        return {7'd0, e.failed, e.stamp, e.heartbeat, e.port, e.id};
    endfunction

    logic [IW-1:0] pos_idx;
    logic          is_self, rem_due, fail_due, rem_cap;
    assign pos_idx  = pos_reg[IW-1:0];
    assign is_self  = (head.id == self_id_reg) && (head.port == self_port_reg);
    assign rem_due  = (now_reg - head.since) >= remove_to_reg;
    assign fail_due = (now_reg - head.stamp) >= fail_to_reg;
    assign rem_cap  = (rem_cnt_reg == 6'(MAX_REMOVALS));

    always_comb begin
        entry_t upd;
        state_next     = state_reg;
        pos_next       = pos_reg;
        pass_next      = pass_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_ok_next   = free_ok_reg;
        free_idx_next  = free_idx_reg;
        rem_cnt_next   = rem_cnt_reg;
        ovalid_next    = ovalid_reg && !m_tready;
        odata_next     = odata_reg;
        ostat_next     = ostat_reg;
        olast_next     = olast_reg;
        shift          = 1'b0;
        clear_all      = 1'b0;
        upd            = head;
        head_new       = head;

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_take) begin
                    pos_next     = '0;
                    pass_next    = 1'b0;
                    found_next   = 1'b0;
                    free_ok_next = 1'b0;
                    rem_cnt_next = '0;
                    if (kind_t'(s_tuser) == KIND_CLEAR) begin
                        clear_all   = 1'b1;
                        ovalid_next = 1'b1;
                        odata_next  = '0;
                        ostat_next  = ST_CLEARED;
                        olast_next  = 1'b1;
                    end else begin
                        state_next = FSM_WALK;
                    end
                end
            end
            FSM_WALK: begin
                shift = 1'b1;
                unique case (kind_reg)
                    KIND_MERGE: begin
                        if (!pass_reg) begin
                            if (head.valid) begin
                                if (!found_reg && head.id == id_reg) begin
                                    found_next     = 1'b1;
                                    found_idx_next = pos_idx;
                                end
                            end else if (!free_ok_reg) begin
                                free_ok_next  = 1'b1;
                                free_idx_next = pos_idx;
                            end
                        end else if (found_reg && pos_idx == found_idx_reg) begin
                            if (hb_reg > head.heartbeat) begin
                                upd.heartbeat = hb_reg;
                                upd.stamp     = now_reg;
                                upd.failed    = 1'b0;
                                ostat_next    = ST_UPDATED;
                            end else begin
                                ostat_next = ST_STALE;
                            end
                            head_new   = upd;
                            odata_next = pack_entry(upd);
                        end else if (!found_reg && free_ok_reg && pos_idx == free_idx_reg) begin
                            upd.valid     = 1'b1;
                            upd.id        = id_reg;
                            upd.port      = port_reg;
                            upd.heartbeat = hb_reg;
                            upd.stamp     = now_reg;
                            upd.failed    = 1'b0;
                            upd.since     = '0;
                            head_new      = upd;
                            ostat_next    = ST_ADDED;
                            odata_next    = pack_entry(upd);
                        end
                    end
                    KIND_SWEEP: begin
                        if (head.valid && !is_self) begin
                            if (head.failed) begin
                                if (rem_due && !rem_cap) begin
                                    if (ovalid_reg && !m_tready) begin
                                        shift = 1'b0;   // hold until the beat drains
                                    end else begin
                                        ovalid_next  = 1'b1;
                                        odata_next   = pack_entry(head);
                                        ostat_next   = ST_REMOVED;
                                        olast_next   = 1'b0;
                                        upd.valid    = 1'b0;
                                        upd.failed   = 1'b0;
                                        head_new     = upd;
                                        rem_cnt_next = rem_cnt_reg + 6'd1;
                                    end
                                end
                            end else if (fail_due) begin
                                upd.failed = 1'b1;
                                upd.since  = now_reg;
                                head_new   = upd;
                            end
                        end
                    end
                    KIND_READ: begin
                        if ({{(8-CW){1'b0}}, pos_reg} == {3'd0, slot_reg}) begin
                            if (head.valid) begin
                                odata_next = pack_entry(head);
                                ostat_next = ST_READ_OK;
                            end else begin
                                odata_next = '0;
                                ostat_next = ST_READ_EMPTY;
                            end
                        end
                    end
                    default: ;
                endcase
                if (shift) begin
                    if (pos_reg == CW'(TABLE_DEPTH - 1)) begin
                        pos_next = '0;
                        if (kind_reg == KIND_MERGE && !pass_reg) begin
                            pass_next = 1'b1;
                        end else begin
                            state_next = FSM_DONE;
                        end
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                if (kind_reg == KIND_READ && pos_reg == '0) begin
                    // Default for indexes beyond the table.
                    if ({3'd0, slot_reg} >= 8'(TABLE_DEPTH)) begin
                        odata_next = '0;
                        ostat_next = ST_READ_EMPTY;
                    end
                end
            end
            FSM_DONE: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    olast_next  = 1'b1;
                    unique case (kind_reg)
                        KIND_SWEEP: begin
                            odata_next = '0;
                            ostat_next = ST_SWEPT;
                        end
                        KIND_MERGE: begin
                            if (!found_reg && !free_ok_reg) begin
                                odata_next = {8'd0, 32'd0, hb_reg, port_reg, id_reg};
                                ostat_next = ST_FULL;
                            end
                        end
                        default: ;
                    endcase
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= FSM_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
        pos_reg       <= pos_next;
        pass_reg      <= pass_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        free_ok_reg   <= free_ok_next;
        free_idx_reg  <= free_idx_next;
        rem_cnt_reg   <= rem_cnt_next;
        odata_reg     <= odata_next;
        ostat_reg     <= ostat_next;
        olast_reg     <= olast_next;
        if (s_take) begin
            kind_reg <= kind_t'(s_tuser);
            id_reg   <= s_tdata[31:0];
            port_reg <= s_tdata[47:32];
            hb_reg   <= s_tdata[79:48];
            now_reg  <= s_tdata[111:80];
            slot_reg <= s_tdata[116:112];
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for heartbeat_membership_table_unit.
// Drives merge, sweep, clear and read beats, predicts every result beat from a
// behavioral copy of the membership table, and checks them in order. Needs hbmt_pkg.
`timescale 1ns / 1ps
module tb_top;
    import hbmt_pkg::*;

    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 1000000;

    // Expected result beat.
    typedef struct {
        status_t     status;
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] heartbeat;
        logic [31:0] stamp;
        logic        failed;
        logic        last;
    } member_report_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    heartbeat_membership_table_unit #(.TABLE_DEPTH(DEPTH)) DUT (.*);

    always #2 aclk = ~aclk;

    // Shadow copy of the table and its registers.
    logic [31:0] own_id, fail_limit, remove_limit;
    logic [15:0] own_port;
    logic        tbl_valid [DEPTH];
    logic [31:0] tbl_id [DEPTH];
    logic [15:0] tbl_port [DEPTH];
    logic [31:0] tbl_hb [DEPTH];
    logic [31:0] tbl_stamp [DEPTH];
    logic        tbl_failed [DEPTH];
    logic [31:0] tbl_since [DEPTH];

    member_report_t pending_reports[$];
    int errors = 0;
    int beats_sent = 0;
    int reports_seen = 0;
    int removals_seen = 0;
    longint cycles = 0;
    logic stall_enable = 1'b1;

    // Recent ids, reused so that merges hit existing members.
    logic [31:0] known_ids[$];

    function automatic member_report_t slot_report(status_t st, int i, logic lst);
        member_report_t r;
        r.status = st; r.id = tbl_id[i]; r.port = tbl_port[i];
        r.heartbeat = tbl_hb[i]; r.stamp = tbl_stamp[i];
        r.failed = tbl_failed[i]; r.last = lst;
        return r;
    endfunction

    function automatic member_report_t plain_report(status_t st);
        member_report_t r;
        r.status = st; r.id = '0; r.port = '0; r.heartbeat = '0;
        r.stamp = '0; r.failed = 1'b0; r.last = 1'b1;
        return r;
    endfunction

    // Appends one expected beat at the tail of the queue.
    function automatic void queue_report(member_report_t r);
        pending_reports.insert(pending_reports.size(), r);
    endfunction

    task automatic reset_table();
        own_id = '0; own_port = '0;
        fail_limit = FAIL_TO_RESET; remove_limit = REMOVE_TO_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i] = 1'b0; tbl_failed[i] = 1'b0;
            tbl_id[i] = '0; tbl_port[i] = '0; tbl_hb[i] = '0;
            tbl_stamp[i] = '0; tbl_since[i] = '0;
        end
    endtask

    // Updates the shadow table for one accepted beat and queues its results.
    task automatic apply_membership(kind_t kind, logic [31:0] id, logic [15:0] port,
                                    logic [31:0] hb, logic [31:0] now, logic [4:0] slot);
        int found, free_slot;
        member_report_t r;
        found = -1; free_slot = -1;
        case (kind)
            KIND_MERGE: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (tbl_valid[i]) begin
                        if (found < 0 && tbl_id[i] == id) found = i;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (found >= 0) begin
                    if (hb > tbl_hb[found]) begin
                        tbl_hb[found] = hb; tbl_stamp[found] = now;
                        tbl_failed[found] = 1'b0;
                        queue_report(slot_report(ST_UPDATED, found, 1'b1));
                    end else begin
                        queue_report(slot_report(ST_STALE, found, 1'b1));
                    end
                end else if (free_slot >= 0) begin
                    tbl_valid[free_slot] = 1'b1; tbl_id[free_slot] = id;
                    tbl_port[free_slot] = port; tbl_hb[free_slot] = hb;
                    tbl_stamp[free_slot] = now; tbl_failed[free_slot] = 1'b0;
                    tbl_since[free_slot] = '0;
                    queue_report(slot_report(ST_ADDED, free_slot, 1'b1));
                end else begin
                    r = plain_report(ST_FULL);
                    r.id = id; r.port = port; r.heartbeat = hb;
                    queue_report(r);
                end
            end
            KIND_SWEEP: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (!tbl_valid[i]) continue;
                    if (tbl_id[i] == own_id && tbl_port[i] == own_port) continue;
                    if (tbl_failed[i]) begin
                        if (32'(now - tbl_since[i]) >= remove_limit) begin
                            queue_report(slot_report(ST_REMOVED, i, 1'b0));
                            tbl_valid[i] = 1'b0; tbl_failed[i] = 1'b0;
                        end
                    end else if (32'(now - tbl_stamp[i]) >= fail_limit) begin
                        tbl_failed[i] = 1'b1; tbl_since[i] = now;
                    end
                end
                queue_report(plain_report(ST_SWEPT));
            end
            KIND_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) begin
                    tbl_valid[i] = 1'b0; tbl_failed[i] = 1'b0;
                end
                queue_report(plain_report(ST_CLEARED));
            end
            default: begin
                if (tbl_valid[slot])
                    queue_report(slot_report(ST_READ_OK, slot, 1'b1));
                else
                    queue_report(plain_report(ST_READ_EMPTY));
            end
        endcase
    endtask

    // Sends one beat after a random gap; predicts at acceptance. Valid drops
    // only for a gap, so a beat with no gap follows its predecessor directly.
    task automatic send_beat(kind_t kind, logic [31:0] id, logic [15:0] port,
                             logic [31:0] hb, logic [31:0] now, logic [4:0] slot);
        int gap;
        gap = stall_enable ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser <= kind;
        s_tdata <= {3'b0, slot, now, hb, port, id};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        apply_membership(kind, id, port, hb, now, slot);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [31:0] value);
        @(negedge aclk);
        cfg_index <= idx; cfg_data <= value; cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SELF_ID:   own_id = value;
            CFG_SELF_PORT: own_port = value[15:0];
            CFG_FAIL_TO:   fail_limit = value;
            default:       remove_limit = value;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drops valid, then waits until every predicted beat has arrived, plus a
    // short settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (3 * DEPTH) @(negedge aclk);
    endtask

    // Result side: random ready stalls, then compare against the oldest expectation.
    initial begin
        int hold;
        forever begin
            @(negedge aclk);
            hold = stall_enable ? $urandom_range(0, 9) : 0;
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            check_report();
        end
    end

    task automatic check_report();
        member_report_t e;
        if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result beat status=%0d id=%h", $time, m_tuser,
                     m_tdata[31:0]);
            errors++;
            return;
        end
        e = pending_reports.pop_front();
        reports_seen++;
        if (e.status == ST_REMOVED) removals_seen++;
        if (m_tuser !== e.status || m_tdata[31:0] !== e.id || m_tdata[47:32] !== e.port
            || m_tdata[79:48] !== e.heartbeat || m_tdata[111:80] !== e.stamp
            || m_tdata[112] !== e.failed || m_tlast !== e.last) begin
            $display("%0t: mismatch expected st=%0d id=%h port=%h hb=%h t=%h f=%b l=%b",
                     $time, e.status, e.id, e.port, e.heartbeat, e.stamp, e.failed, e.last);
            $display("%0t:          actual   st=%0d id=%h port=%h hb=%h t=%h f=%b l=%b",
                     $time, m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[79:48],
                     m_tdata[111:80], m_tdata[112], m_tlast);
            errors++;
        end
    endtask

    // Directed: field extremes, every kind, stale/update/full, own-entry skip,
    // wraparound ages, and reads of empty and valid slots.
    task automatic test_directed();
        send_beat(KIND_READ, '0, '0, '0, '0, 5'd0);
        send_beat(KIND_READ, '1, '1, '1, '1, 5'd31);
        send_beat(KIND_MERGE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, '1);
        send_beat(KIND_MERGE, 32'h0, 16'h0, 32'h0, 32'h0, '0);
        send_beat(KIND_MERGE, 32'h0, 16'h1, 32'h0, 32'h1, '0);      // stale, equal
        send_beat(KIND_MERGE, 32'h0, 16'h2, 32'h1, 32'h2, '0);      // update
        send_beat(KIND_MERGE, 32'hFFFF_FFFF, 16'h0, 32'h5, 32'h3, '0); // stale, smaller
        send_beat(KIND_MERGE, own_id, own_port, 32'h7, 32'h0, '0);  // own entry
        send_beat(KIND_READ, '0, '0, '0, '0, 5'd1);
        send_beat(KIND_SWEEP, '0, '0, '0, 32'h4, '0);
        send_beat(KIND_SWEEP, '0, '0, '0, 32'h5, '0);               // wrap age ok
        send_beat(KIND_SWEEP, '0, '0, '0, 32'h1A, '0);
        send_beat(KIND_READ, '0, '0, '0, '0, 5'd0);
        send_beat(KIND_MERGE, 32'h0, 16'h0, 32'h9, 32'h1B, '0);     // revive failed
        send_beat(KIND_SWEEP, '0, '0, '0, 32'h40, '0);
        send_beat(KIND_SWEEP, '0, '0, '0, 32'h60, '0);              // removals
        for (int i = 0; i < DEPTH + 1; i++)
            send_beat(KIND_MERGE, 32'h100 + i, 16'(i), 32'(i), 32'h70, 5'(i));
        send_beat(KIND_READ, '0, '0, '0, '0, 5'd31);
        send_beat(KIND_CLEAR, '0, '0, '0, '0, '0);
        send_beat(KIND_READ, '0, '0, '0, '0, 5'd0);
    endtask

    // Well-formed membership traffic: time advances, known members gossip,
    // sweeps age the table; occasional clears and noise merges.
    task automatic test_random(int count);
        logic [31:0] now, id;
        int pick;
        now = $urandom;
        for (int n = 0; n < count; n++) begin
            now = now + $urandom_range(0, 6);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                if (known_ids.size() > 0 && $urandom_range(0, 2) != 0)
                    id = known_ids[$urandom_range(0, known_ids.size() - 1)];
                else begin
                    id = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 40));
                    known_ids.insert(known_ids.size(), id);
                    if (known_ids.size() > 40) void'(known_ids.pop_front());
                end
                send_beat(KIND_MERGE, id, 16'($urandom), $urandom_range(0, 3) == 0 ?
                          $urandom : 32'($urandom_range(0, 30)), now, 5'($urandom));
            end else if (pick < 80) begin
                send_beat(KIND_SWEEP, $urandom, 16'($urandom), $urandom, now, 5'($urandom));
            end else if (pick < 98) begin
                send_beat(KIND_READ, $urandom, 16'($urandom), $urandom, now, 5'($urandom));
            end else begin
                send_beat(KIND_CLEAR, $urandom, 16'($urandom), $urandom, now, 5'($urandom));
            end
        end
    endtask

    // Configuration phases, each followed by random traffic.
    task automatic test_settings();
        write_register(CFG_SELF_ID, 32'd3);
        write_register(CFG_SELF_PORT, 32'h0000_FFFF);
        write_register(CFG_FAIL_TO, 32'd3);
        write_register(CFG_REMOVE_TO, 32'd6);
        send_beat(KIND_MERGE, 32'd3, 16'hFFFF, 32'd1, 32'd0, '0);
        test_random(130);
        wait_drained();
        write_register(CFG_FAIL_TO, 32'd0);
        write_register(CFG_REMOVE_TO, 32'd0);
        write_register(CFG_SELF_ID, 32'hFFFF_FFFF);
        test_random(100);
        wait_drained();
        write_register(CFG_FAIL_TO, 32'hFFFF_FFFF);
        write_register(CFG_REMOVE_TO, 32'hFFFF_FFFF);
        write_register(CFG_SELF_PORT, 32'h0000_0000);
        test_random(60);
        wait_drained();
        write_register(CFG_FAIL_TO, 32'd10);
        write_register(CFG_REMOVE_TO, 32'd15);
        write_register(CFG_SELF_ID, 32'd0);
        stall_enable = 1'b0;   // a stretch with no idling on either side
        test_random(40);
        stall_enable = 1'b1;
        test_random(40);
    endtask

    // Cycle watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("heartbeat_membership_table_unit regression: fail");
            $finish;
        end
    end

    initial begin
        reset_table();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);
        test_directed();
        wait_drained();     // sender holds off until every result is in
        test_settings();
        wait_drained();
        $display("Sent %0d input beats; checked %0d result beats, %0d of them removals.",
                 beats_sent, reports_seen, removals_seen);
        if (errors == 0)
            $display("heartbeat_membership_table_unit regression: pass");
        else
            $display("heartbeat_membership_table_unit regression: fail");
        $finish;
    end

endmodule
